@@ design/smpq_pkg.sv @@
// Shared types and constants for the stable minimum priority queue.
`default_nettype none
package smpq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 5;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_HOLD
	} ctl_state_t;

	typedef struct packed {
		logic        command;
		logic [15:0] priority_req;
		logic [7:0]  age;
		logic        sex;
		logic [15:0] tag;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [15:0]      head_priority;
		logic [7:0]       head_age;
		logic             head_sex;
		logic [15:0]      head_tag;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	typedef struct packed {
		logic [15:0] prio;
		logic [7:0]  age;
		logic        sex;
		logic [15:0] tag;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
	} ctl_cmd_t;

endpackage
`default_nettype wire

@@ design/smpq_ctrl.sv @@
// Handshake controller: tracks the result register and issues request loads.
`default_nettype none
module smpq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output smpq_pkg::ctl_cmd_t      cmd
);
	import smpq_pkg::*;

	ctl_state_t state_q, state_nxt;
	logic       accept;

	assign accept = in_valid && in_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_HOLD;
			end
			ST_HOLD: begin
				if (accept) state_nxt = ST_HOLD;
				else if (out_ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// result register may be refilled in the cycle it is drained
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_HOLD: begin
				in_ready  = out_ready;
				out_valid = 1'b1;
			end
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
		cmd.load = accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

endmodule
`default_nettype wire

@@ design/smpq_dp.sv @@
// Datapath: sorted row of entry cells, fill count and result register.
`default_nettype none
module smpq_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire smpq_pkg::ctl_cmd_t cmd,
	input  wire smpq_pkg::req_t     req,
	output smpq_pkg::rsp_t          rsp
);
	import smpq_pkg::*;

	entry_t           entries_q [CAPACITY];
	entry_t           ins_nxt   [CAPACITY];
	entry_t           del_nxt   [CAPACITY];
	entry_t           new_entry;
	logic [CAPACITY-1:0] le;
	logic [CNT_W-1:0] fill_q, fill_nxt;
	logic             is_full, is_empty, do_enq, do_deq;
	rsp_t             rsp_q, rsp_nxt;
	logic [CNT_W+OCC_W-1:0] occ_wide;

	assign new_entry = '{prio: req.priority_req, age: req.age, sex: req.sex, tag: req.tag};
	assign is_full   = (fill_q == CNT_W'(CAPACITY));
	assign is_empty  = (fill_q == '0);
	assign do_enq    = cmd.load && (req.command == CMD_ENQ) && !is_full;
	assign do_deq    = cmd.load && (req.command == CMD_DEQ) && !is_empty;

	// each cell decides in parallel: keep, take the new entry, or shift
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign le[i] = (CNT_W'(i) < fill_q) && (entries_q[i].prio <= req.priority_req);
		if (i == 0) begin : g_first
			assign ins_nxt[i] = le[i] ? entries_q[i] : new_entry;
		end else begin : g_rest
			assign ins_nxt[i] = le[i] ? entries_q[i] :
				(le[i-1] ? new_entry : entries_q[i-1]);
		end
		if (i == CAPACITY - 1) begin : g_last
			assign del_nxt[i] = entries_q[i];
		end else begin : g_mid
			assign del_nxt[i] = entries_q[i+1];
		end
	end

	always_comb begin
		fill_nxt = fill_q;
		if (do_enq) fill_nxt = fill_q + 1'b1;
		else if (do_deq) fill_nxt = fill_q - 1'b1;
		occ_wide = (CNT_W + OCC_W)'(fill_nxt);

		rsp_nxt           = '0;
		rsp_nxt.occupancy = occ_wide[OCC_W-1:0];
		if (req.command == CMD_ENQ) begin
			rsp_nxt.status = is_full ? STATUS_FULL : STATUS_OK;
		end else if (is_empty) begin
			rsp_nxt.status = STATUS_EMPTY;
		end else begin
			rsp_nxt.status        = STATUS_OK;
			rsp_nxt.head_priority = entries_q[0].prio;
			rsp_nxt.head_age      = entries_q[0].age;
			rsp_nxt.head_sex      = entries_q[0].sex;
			rsp_nxt.head_tag      = entries_q[0].tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fill_q <= '0;
		else fill_q <= fill_nxt;
	end

	always_ff @(posedge clk) begin
		if (do_enq) begin
			entries_q <= ins_nxt;
		end else if (do_deq) begin
			entries_q <= del_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) rsp_q <= rsp_nxt;
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

@@ design/stable_min_priority_queue.sv @@
// Top level of the stable minimum priority queue.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | in_data  (command, priority, age, sex, tag)
//  out     | output    | out_valid / out_ready | out_data (status, head fields, occupancy)
//
// A taken request's result is registered and shows on out_data in the next cycle.
// Cells compare to the new priority in parallel; one request per cycle while out_ready is high.
// A new request is taken in the same cycle the waiting result is taken; while a result
// stalls, in_ready stays low. Reset clears the fill count; entry contents are not reset.
`default_nettype none
module stable_min_priority_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire smpq_pkg::req_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output smpq_pkg::rsp_t     out_data
);
	import smpq_pkg::*;

	ctl_cmd_t cmd;

	smpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	smpq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (in_data),
		.rsp    (out_data)
	);

endmodule
`default_nettype wire
